/* hdl/md5_message_digest_macros.svh */
// assertion macros for the md5 message digest block
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every rising clock edge outside reset
`define MD5MD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("md5md assertion failed");
// condition that must never be true outside reset
`define MD5MD_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("md5md forbidden condition seen");
`else
`define MD5MD_ASSERT(lbl, clk, rstn, prop)
`define MD5MD_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* hdl/md5md_pkg.sv */
// shared types, constants and round tables of the md5 message digest block
`timescale 1ns / 1ps

package md5md_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [2:0] MAX_BYTES   = 3'd4;
	localparam logic [3:0] LEN_LO_IDX  = 4'd14;
	localparam logic [3:0] LEN_HI_IDX  = 4'd15;
	localparam logic [3:0] LAST_WIDX   = 4'd15;
	localparam logic [5:0] LAST_ROUND  = 6'd63;
	localparam logic [1:0] LAST_DIGEST = 2'd3;

	localparam logic [31:0] K_TABLE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] SHIFT_TABLE [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_FEED,
		ST_PAD0,
		ST_PAD,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       absorb;
		logic       pad80;
		logic       padw;
		logic       load;
		logic       round;
		logic       feed;
		logic       rearm;
		logic       len_ok;
		logic [3:0] widx;
		logic [5:0] rc;
		logic [1:0] oidx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic word_wr;
	} stat_t;

	function automatic logic [31:0] round_k(input logic [5:0] j);
		return K_TABLE[j];
	endfunction

	function automatic logic [4:0] round_shift(input logic [5:0] j);
		return SHIFT_TABLE[{j[5:4], j[1:0]}];
	endfunction

	// message word used by round j
	function automatic logic [3:0] msg_index(input logic [5:0] j);
		logic [3:0] jl;
		logic [3:0] g;
		jl = j[3:0];
		case (j[5:4])
			2'd0:    g = jl;
			2'd1:    g = 4'(jl * 4'd5 + 4'd1);
			2'd2:    g = 4'(jl * 4'd3 + 4'd5);
			default: g = 4'(jl * 4'd7);
		endcase
		return g;
	endfunction

endpackage

/* hdl/md5md_ctrl.sv */
// sequencing state machine: absorb, padding, compression rounds and digest beats
`timescale 1ns / 1ps

module md5md_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	input  md5md_pkg::stat_t   stat,
	output md5md_pkg::cmd_t    cmd
);

	md5md_pkg::state_t state_q, state_d;
	logic [3:0] widx_q, widx_d;
	logic [5:0] rc_q, rc_d;
	logic [1:0] oidx_q, oidx_d;
	logic       last_q, last_d;
	logic       pad0_q, pad0_d;
	logic       len_ok_q, len_ok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= md5md_pkg::ST_IDLE;
			widx_q   <= '0;
			rc_q     <= '0;
			oidx_q   <= '0;
			last_q   <= 1'b0;
			pad0_q   <= 1'b0;
			len_ok_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			widx_q   <= widx_d;
			rc_q     <= rc_d;
			oidx_q   <= oidx_d;
			last_q   <= last_d;
			pad0_q   <= pad0_d;
			len_ok_q <= len_ok_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		widx_d     = widx_q;
		rc_d       = rc_q;
		oidx_d     = oidx_q;
		last_d     = last_q;
		pad0_d     = pad0_q;
		len_ok_d   = len_ok_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd        = '0;
		cmd.widx   = widx_q;
		cmd.rc     = rc_q;
		cmd.oidx   = oidx_q;
		cmd.len_ok = len_ok_q;
		case (state_q)
			md5md_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.absorb = 1'b1;
					last_d     = last;
					if (stat.word_wr) begin
						widx_d = widx_q + 4'd1;
					end
					if (stat.word_wr && widx_q == md5md_pkg::LAST_WIDX) begin
						cmd.load = 1'b1;
						state_d  = md5md_pkg::ST_COMP;
					end else if (last) begin
						state_d = md5md_pkg::ST_PAD0;
					end
				end
			end
			md5md_pkg::ST_COMP: begin
				cmd.round = 1'b1;
				rc_d      = rc_q + 6'd1;
				if (rc_q == md5md_pkg::LAST_ROUND) begin
					state_d = md5md_pkg::ST_FEED;
				end
			end
			md5md_pkg::ST_FEED: begin
				cmd.feed = 1'b1;
				if (!last_q) begin
					state_d = md5md_pkg::ST_IDLE;
				end else if (!pad0_q) begin
					state_d = md5md_pkg::ST_PAD0;
				end else if (len_ok_q) begin
					state_d = md5md_pkg::ST_OUT;
				end else begin
					// length did not fit: one more block of zeros and length
					len_ok_d = 1'b1;
					state_d  = md5md_pkg::ST_PAD;
				end
			end
			md5md_pkg::ST_PAD0: begin
				cmd.pad80 = 1'b1;
				pad0_d    = 1'b1;
				len_ok_d  = (widx_q < md5md_pkg::LEN_LO_IDX);
				widx_d    = widx_q + 4'd1;
				if (widx_q == md5md_pkg::LAST_WIDX) begin
					cmd.load = 1'b1;
					state_d  = md5md_pkg::ST_COMP;
				end else begin
					state_d = md5md_pkg::ST_PAD;
				end
			end
			md5md_pkg::ST_PAD: begin
				cmd.padw = 1'b1;
				widx_d   = widx_q + 4'd1;
				if (widx_q == md5md_pkg::LAST_WIDX) begin
					cmd.load = 1'b1;
					state_d  = md5md_pkg::ST_COMP;
				end
			end
			md5md_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					oidx_d = oidx_q + 2'd1;
					if (oidx_q == md5md_pkg::LAST_DIGEST) begin
						cmd.rearm = 1'b1;
						last_d    = 1'b0;
						pad0_d    = 1'b0;
						len_ok_d  = 1'b0;
						widx_d    = '0;
						state_d   = md5md_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = md5md_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/md5md_datapath.sv */
// byte packing, block buffer, round unit and chaining words
`timescale 1ns / 1ps

module md5md_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  md5md_pkg::cmd_t   cmd,
	output md5md_pkg::stat_t  stat,
	input  logic [31:0]       data_word,
	input  logic [2:0]        valid_bytes,
	output logic [31:0]       digest_word
);

	logic [31:0] buf_q [16];
	logic [31:0] chain_q [4];
	logic [31:0] rr_q [4];
	logic [63:0] bitlen_q;
	logic [23:0] pend_q;
	logic [1:0]  pcnt_q;

	logic [2:0]  nbytes;
	logic [31:0] word_masked;
	logic [55:0] merged;
	logic [2:0]  total;
	logic        wr_en;
	logic [31:0] wr_data;
	logic [31:0] pad80_word;
	logic [31:0] padw_word;

	logic [31:0] ra, rb, rc, rd;
	logic [31:0] f, t, new_b;
	logic [63:0] rot;

	// counts above four behave as four
	assign nbytes = (valid_bytes > md5md_pkg::MAX_BYTES) ? md5md_pkg::MAX_BYTES : valid_bytes;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			word_masked[8*i +: 8] = (3'(i) < nbytes) ? data_word[8*i +: 8] : 8'h00;
		end
	end

	// held bytes first, new bytes packed right above them
	assign merged = ({24'h0, word_masked} << {pcnt_q, 3'b000}) | {32'h0, pend_q};
	assign total  = {1'b0, pcnt_q} + nbytes;
	assign stat.word_wr = total[2];

	assign pad80_word = {8'h00, pend_q} | ({24'h0, md5md_pkg::PAD_BYTE} << {pcnt_q, 3'b000});

	always_comb begin
		padw_word = '0;
		if (cmd.len_ok && cmd.widx == md5md_pkg::LEN_LO_IDX) begin
			padw_word = bitlen_q[31:0];
		end else if (cmd.len_ok && cmd.widx == md5md_pkg::LEN_HI_IDX) begin
			padw_word = bitlen_q[63:32];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = padw_word;
		if (cmd.absorb && stat.word_wr) begin
			wr_en   = 1'b1;
			wr_data = merged[31:0];
		end else if (cmd.pad80) begin
			wr_en   = 1'b1;
			wr_data = pad80_word;
		end else if (cmd.padw) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[cmd.widx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			pcnt_q   <= '0;
			bitlen_q <= '0;
		end else if (cmd.rearm) begin
			pend_q   <= '0;
			pcnt_q   <= '0;
			bitlen_q <= '0;
		end else if (cmd.absorb) begin
			pend_q   <= stat.word_wr ? merged[55:32] : merged[23:0];
			pcnt_q   <= total[1:0];
			bitlen_q <= bitlen_q + {58'h0, nbytes, 3'b000};
		end
	end

	// one md5 round per cycle
	assign ra = rr_q[0];
	assign rb = rr_q[1];
	assign rc = rr_q[2];
	assign rd = rr_q[3];

	always_comb begin
		case (cmd.rc[5:4])
			2'd0:    f = (rb & rc) | (~rb & rd);
			2'd1:    f = (rd & rb) | (~rd & rc);
			2'd2:    f = rb ^ rc ^ rd;
			default: f = rc ^ (rb | ~rd);
		endcase
	end

	assign t     = ra + f + md5md_pkg::round_k(cmd.rc) + buf_q[md5md_pkg::msg_index(cmd.rc)];
	assign rot   = {t, t} << md5md_pkg::round_shift(cmd.rc);
	assign new_b = rb + rot[63:32];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 4; i++) begin
				rr_q[i] <= chain_q[i];
			end
		end else if (cmd.round) begin
			rr_q[0] <= rd;
			rr_q[1] <= new_b;
			rr_q[2] <= rb;
			rr_q[3] <= rc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= md5md_pkg::IV_A;
			chain_q[1] <= md5md_pkg::IV_B;
			chain_q[2] <= md5md_pkg::IV_C;
			chain_q[3] <= md5md_pkg::IV_D;
		end else if (cmd.rearm) begin
			chain_q[0] <= md5md_pkg::IV_A;
			chain_q[1] <= md5md_pkg::IV_B;
			chain_q[2] <= md5md_pkg::IV_C;
			chain_q[3] <= md5md_pkg::IV_D;
		end else if (cmd.feed) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[i] <= chain_q[i] + rr_q[i];
			end
		end
	end

	assign digest_word = chain_q[cmd.oidx];

endmodule

/* hdl/md5_message_digest.sv */
// md5 message digest top level: controller, datapath and checks
`timescale 1ns / 1ps
`include "md5_message_digest_macros.svh"

// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_ready  | data_word, valid_bytes, last
// output   | out_valid / out_ready| digest_word, word_index, last_word
//
// a message word is taken in one cycle; the word that completes a block adds
// 64 rounds on the shared round unit and a feed-forward add to the chaining words
// the last word adds padding writes (one per remaining buffer word), one or two
// compressions, then four digest beats; input is held off until the fourth beat
// arst_n clears the control state and loads the initial chaining vector
// a stalled output beat holds while out_ready is low

module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	md5md_pkg::cmd_t  ctrl_cmd;
	md5md_pkg::stat_t dp_stat;

	// sequencer: owns buffer word index, round counter and digest beat count
	md5md_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	// storage and arithmetic: packing, block buffer, round unit, chaining words
	md5md_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctrl_cmd),
		.stat        (dp_stat),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.digest_word (digest_word)
	);

	// beat index comes straight from the controller's digest counter
	assign word_index = ctrl_cmd.oidx;
	assign last_word  = (ctrl_cmd.oidx == md5md_pkg::LAST_DIGEST);

	// input is never taken while a digest is being delivered
	`MD5MD_NEVER(a_no_overlap, clk, arst_n, in_ready && out_valid)
	// after the final digest beat the block is ready for a new message
	`MD5MD_ASSERT(a_rearm_ready, clk, arst_n, (out_valid && out_ready && last_word) |=> in_ready)
	// a round-register load always starts a compression
	`MD5MD_ASSERT(a_load_round, clk, arst_n, ctrl_cmd.load |=> ctrl_cmd.round)
	// the last round is always followed by the feed-forward add
	`MD5MD_ASSERT(a_round_feed, clk, arst_n,
		(ctrl_cmd.round && ctrl_cmd.rc == md5md_pkg::LAST_ROUND) |=> ctrl_cmd.feed)

endmodule
